[rtl/core/additive_sine_oscillator_bank_top_assert.svh]
// Assertion macros used by the oscillator bank controller.
`ifndef ADDITIVE_SINE_OSCILLATOR_BANK_TOP_ASSERT_SVH
`define ADDITIVE_SINE_OSCILLATOR_BANK_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define ASOB_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("asob: implication check failed");

// Next-cycle implication, checked out of reset.
`define ASOB_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("asob: next-cycle check failed");

`endif

[rtl/core/asob_pkg.sv]
// Shared types and constants of the additive sine oscillator bank.
package asob_pkg;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_SYNC   = 2'd2
    } t_op;

    localparam int SLOT_W   = 6;
    localparam int FREQ_W   = 24;
    localparam int AMP_W    = 16;
    localparam int COUNT_W  = 7;
    localparam int HZ_W     = 32;
    localparam int PHASE_W  = 32;
    localparam int SAMPLE_W = 22;
    localparam int SINE_W   = 16;

    localparam logic [HZ_W-1:0] HZ_RESET = 32'd24931631;

    localparam int OUT_MAX = 2097151;
    localparam int OUT_MIN = -2097152;

    // 2*pi in unsigned Q30
    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

    // Taylor series divisors (2n)(2n+1) for n = 1..6
    localparam logic [63:0] TAYLOR_DIV [6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

    typedef struct packed {
        logic clear_wr;
        logic load_wr;
        logic load_clr_phase;
        logic issue;
        logic acc_clr;
        logic sync_flip;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic busy;
    } t_dp_stat;

endpackage

[rtl/core/asob_datapath.sv]
// Partial memories, sine ROM, per-partial pipeline and the sample accumulator.
module asob_datapath #(
    parameter int MAX_PARTIALS    = 64,
    parameter int SINE_TABLE_SIZE = 4096,
    parameter int AW              = 6
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  asob_pkg::t_dp_cmd                 i_cmd,
    input  logic [AW-1:0]                     i_addr,
    input  logic [asob_pkg::FREQ_W-1:0]       i_freq,
    input  logic [asob_pkg::AMP_W-1:0]        i_amp,
    input  logic                              i_cfg_wr_en,
    input  logic [asob_pkg::HZ_W-1:0]         i_cfg_wr_data,
    output asob_pkg::t_dp_stat                o_stat,
    output logic signed [asob_pkg::SAMPLE_W-1:0] o_sample_out
);
    import asob_pkg::*;

    localparam int IW    = (SINE_TABLE_SIZE > 1) ? $clog2(SINE_TABLE_SIZE) : 1;
    localparam int FA_W  = FREQ_W + AMP_W;
    localparam int ACC_W = (17 + $clog2(MAX_PARTIALS + 1) > SAMPLE_W) ?
                           (17 + $clog2(MAX_PARTIALS + 1)) : SAMPLE_W;
    localparam logic [63:0] ROM_DIV = 64'(4 * SINE_TABLE_SIZE);
    localparam logic [63:0] ROM_N   = 64'(SINE_TABLE_SIZE);
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(OUT_MAX);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(OUT_MIN);

    typedef logic signed [SINE_W-1:0] t_rom [SINE_TABLE_SIZE];

    function automatic logic [63:0] sin_q30(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (int n = 0; n < 6; n++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[n];
            if ((n & 1) == 0) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return sum;
    endfunction

    function automatic t_rom build_rom();
        t_rom        rom;
        logic [63:0] k4;
        logic [63:0] m4;
        logic [63:0] theta;
        logic [63:0] mag;
        logic        neg;
        for (int k = 0; k < SINE_TABLE_SIZE; k++) begin
            k4  = 64'(k) * 64'd4;
            neg = 1'b0;
            if (k4 <= ROM_N) begin
                m4 = k4;
            end else if (k4 <= 2 * ROM_N) begin
                m4 = 2 * ROM_N - k4;
            end else if (k4 <= 3 * ROM_N) begin
                m4  = k4 - 2 * ROM_N;
                neg = 1'b1;
            end else begin
                m4  = 4 * ROM_N - k4;
                neg = 1'b1;
            end
            theta = (TWO_PI_Q30 * m4) / ROM_DIV;
            mag   = (sin_q30(theta) * 64'd32767 + (64'd1 << 29)) >> 30;
            if (mag > 64'd32767) begin
                mag = 64'd32767;
            end
            rom[k] = neg ? -SINE_W'(mag) : SINE_W'(mag);
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

    logic [FA_W-1:0]    r_fa_mem [MAX_PARTIALS];
    logic [PHASE_W-1:0] r_ph_mem [MAX_PARTIALS];

    logic [HZ_W-1:0]    r_hz;
    logic               r_rev;

    // stage 1: memory read data
    logic               r_v1;
    logic [AW-1:0]      r_a1;
    logic [FA_W-1:0]    r_fa_rd;
    logic [PHASE_W-1:0] r_ph_rd;
    // stage 2: step and table index
    logic               r_v2;
    logic [AW-1:0]      r_a2;
    logic [PHASE_W-1:0] r_step2;
    logic [PHASE_W-1:0] r_ph2;
    logic [IW-1:0]      r_idx2;
    logic [AMP_W-1:0]   r_amp2;
    // stage 3: sine value
    logic               r_v3;
    logic signed [SINE_W-1:0] r_sine3;
    logic [AMP_W-1:0]   r_amp3;
    // stage 4: product
    logic               r_v4;
    logic signed [AMP_W+SINE_W:0] r_prod4;

    logic signed [ACC_W-1:0]    r_acc;
    logic signed [SAMPLE_W-1:0] r_out;

    logic [FREQ_W+HZ_W-1:0] step_prod;
    logic [PHASE_W+IW-1:0]  idx_prod;
    logic [PHASE_W-1:0]     new_phase;
    logic                   ph_we;
    logic [AW-1:0]          ph_addr;
    logic [PHASE_W-1:0]     ph_data;
    logic signed [16:0]     term;
    logic signed [SAMPLE_W-1:0] sat_val;

    assign step_prod = (FREQ_W+HZ_W)'(r_fa_rd[FA_W-1:AMP_W]) * (FREQ_W+HZ_W)'(r_hz);
    assign idx_prod  = (PHASE_W+IW)'(r_ph_rd) * (PHASE_W+IW)'(SINE_TABLE_SIZE);
    assign new_phase = r_rev ? (r_ph2 - r_step2) : (r_ph2 + r_step2);

    // writeback of an advanced phase wins; loads and clears only come while the pipe is empty
    assign ph_we   = r_v2 | i_cmd.clear_wr | (i_cmd.load_wr & i_cmd.load_clr_phase);
    assign ph_addr = r_v2 ? r_a2 : i_addr;
    assign ph_data = r_v2 ? new_phase : '0;

    // floor of the Q1.15 product scaled down by 2^16
    assign term = r_prod4[AMP_W+SINE_W:16];

    always_comb begin
        if (r_acc > SAT_HI) begin
            sat_val = SAMPLE_W'(SAT_HI);
        end else if (r_acc < SAT_LO) begin
            sat_val = SAMPLE_W'(SAT_LO);
        end else begin
            sat_val = r_acc[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_wr || i_cmd.load_wr) begin
            r_fa_mem[i_addr] <= i_cmd.clear_wr ? '0 : {i_freq, i_amp};
        end
        r_fa_rd <= r_fa_mem[i_addr];
    end

    always_ff @(posedge i_clk) begin
        if (ph_we) begin
            r_ph_mem[ph_addr] <= ph_data;
        end
        r_ph_rd <= r_ph_mem[i_addr];
    end

    always_ff @(posedge i_clk) begin
        r_sine3 <= SINE_ROM[r_idx2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hz  <= HZ_RESET;
            r_rev <= 1'b0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_v4  <= 1'b0;
            r_acc <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_hz <= i_cfg_wr_data;
            end
            if (i_cmd.sync_flip) begin
                r_rev <= ~r_rev;
            end
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            if (i_cmd.acc_clr) begin
                r_acc <= '0;
            end else if (r_v4) begin
                r_acc <= r_acc + {{(ACC_W-17){term[16]}}, term};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a1    <= i_addr;
        r_a2    <= r_a1;
        r_step2 <= step_prod[PHASE_W+15:16];
        r_ph2   <= r_ph_rd;
        r_idx2  <= idx_prod[PHASE_W+IW-1:PHASE_W];
        r_amp2  <= r_fa_rd[AMP_W-1:0];
        r_amp3  <= r_amp2;
        r_prod4 <= $signed({1'b0, r_amp3}) * r_sine3;
        if (i_cmd.out_load) begin
            r_out <= sat_val;
        end
    end

    assign o_stat.busy  = r_v1 | r_v2 | r_v3 | r_v4;
    assign o_sample_out = r_out;

endmodule

[rtl/core/asob_ctrl.sv]
// Sequencer for clearing, item decode, partial issue and result handoff.
module asob_ctrl #(
    parameter int MAX_PARTIALS = 64,
    parameter int AW           = 6
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [1:0]                     i_op,
    input  logic [asob_pkg::SLOT_W-1:0]    i_slot,
    input  logic                           i_clear_phase,
    input  logic [asob_pkg::COUNT_W-1:0]   i_partial_count,
    output logic                           o_valid,
    input  logic                           i_ready,
    output asob_pkg::t_dp_cmd              o_cmd,
    output logic [AW-1:0]                  o_addr,
    input  asob_pkg::t_dp_stat             i_stat
);
    import asob_pkg::*;

    localparam int CW = $clog2(MAX_PARTIALS + 1);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_ISSUE = 4'b0100,
        ST_DRAIN = 4'b1000
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_count, n_count;
    logic          r_out_valid, n_out_valid;

    t_dp_cmd       cmd;
    logic          accept;
    logic          slot_ok;
    logic [CW-1:0] count_clamp;

    assign accept  = i_valid && (r_state == ST_IDLE);
    assign slot_ok = ({26'd0, i_slot} < 32'(MAX_PARTIALS));
    assign count_clamp = ({25'd0, i_partial_count} > 32'(MAX_PARTIALS)) ?
                         CW'(MAX_PARTIALS) : CW'(i_partial_count);

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_count = r_count;
        cmd     = '0;
        o_addr  = r_idx[AW-1:0];
        cmd.load_clr_phase = i_clear_phase;
        case (r_state)
            ST_CLEAR: begin
                cmd.clear_wr = 1'b1;
                n_idx        = CW'(r_idx + 1'b1);
                if (r_idx == CW'(MAX_PARTIALS - 1)) begin
                    n_idx   = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    case (i_op)
                        OP_LOAD: begin
                            cmd.load_wr = slot_ok;
                            o_addr      = AW'(i_slot);
                        end
                        OP_SAMPLE: begin
                            cmd.acc_clr = 1'b1;
                            n_idx       = '0;
                            n_count     = count_clamp;
                            n_state     = (count_clamp == '0) ? ST_DRAIN : ST_ISSUE;
                        end
                        OP_SYNC: begin
                            cmd.sync_flip = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ISSUE: begin
                cmd.issue = 1'b1;
                n_idx     = CW'(r_idx + 1'b1);
                if (CW'(r_idx + 1'b1) == r_count) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // hold the result until the pipe is empty and the output slot is free
                if (!i_stat.busy && (!r_out_valid || i_ready)) begin
                    cmd.out_load = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_idx       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = r_out_valid;
    assign o_cmd   = cmd;

`include "additive_sine_oscillator_bank_top_assert.svh"

    `ASOB_ASSERT_IMP(a_issue_in_range, cmd.issue, r_idx < r_count)
    `ASOB_ASSERT_IMP(a_no_overwrite, cmd.out_load, !r_out_valid || i_ready)
    `ASOB_ASSERT_IMP(a_idle_pipe_empty, r_state == ST_IDLE, !i_stat.busy)
    `ASOB_ASSERT_NXT(a_drain_to_out, (r_state == ST_DRAIN) && !i_stat.busy && !r_out_valid,
                     (r_state == ST_IDLE) && o_valid)

endmodule

[rtl/core/additive_sine_oscillator_bank_top.sv]
// Top level of the additive sine oscillator bank.
// Load and sync transactions are done at acceptance; the block is ready again the next cycle.
// A sample transaction walks N = min(partial_count, MAX_PARTIALS) partials, one per cycle,
// through a four-stage pipeline and the accumulator; an unread earlier result stalls both the
// new result and the next transaction. Reset clears the partial memories with ready low;
// config is taken.
module additive_sine_oscillator_bank_top #(
    parameter int MAX_PARTIALS    = 64,
    parameter int SINE_TABLE_SIZE = 4096
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [1:0]                           i_op,
    input  logic [asob_pkg::SLOT_W-1:0]          i_slot,
    input  logic [asob_pkg::FREQ_W-1:0]          i_freq,
    input  logic [asob_pkg::AMP_W-1:0]           i_amp,
    input  logic                                 i_clear_phase,
    input  logic [asob_pkg::COUNT_W-1:0]         i_partial_count,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [asob_pkg::SAMPLE_W-1:0] o_sample_out,
    input  logic                                 i_cfg_wr_en,
    input  logic [asob_pkg::HZ_W-1:0]            i_cfg_wr_data
);
    import asob_pkg::*;

    localparam int AW = (MAX_PARTIALS > 1) ? $clog2(MAX_PARTIALS) : 1;

    t_dp_cmd       cmd;
    t_dp_stat      stat;
    logic [AW-1:0] addr;

    asob_ctrl #(
        .MAX_PARTIALS (MAX_PARTIALS),
        .AW           (AW)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_op            (i_op),
        .i_slot          (i_slot),
        .i_clear_phase   (i_clear_phase),
        .i_partial_count (i_partial_count),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_cmd           (cmd),
        .o_addr          (addr),
        .i_stat          (stat)
    );

    asob_datapath #(
        .MAX_PARTIALS    (MAX_PARTIALS),
        .SINE_TABLE_SIZE (SINE_TABLE_SIZE),
        .AW              (AW)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_addr        (addr),
        .i_freq        (i_freq),
        .i_amp         (i_amp),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_stat        (stat),
        .o_sample_out  (o_sample_out)
    );

endmodule
